[rtl/core/utf8d_pkg.sv]
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned RemW   = 2;

  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
    logic              truncated;
    logic              string_end;
  } out_item_t;

  // lead byte classes
  typedef enum logic [1:0] {
    LeadSingle = 2'd0,
    LeadTwo    = 2'd1,
    LeadThree  = 2'd2,
    LeadFour   = 2'd3
  } lead_e;

  function automatic lead_e classify_lead(input logic [ByteW-1:0] b);
    lead_e cls;
    if (b[7] == 1'b0) begin
      cls = LeadSingle;
    end else if (b[7:5] == 3'b110) begin
      cls = LeadTwo;
    end else if (b[7:4] == 4'b1110) begin
      cls = LeadThree;
    end else if (b[7:3] == 5'b11110) begin
      cls = LeadFour;
    end else begin
      // stray continuation or 0xF8 and above: passed out as is
      cls = LeadSingle;
    end
    return cls;
  endfunction

endpackage

[rtl/core/utf8_stream_decoder_top.sv]
// An accepted item is held in the input register, and its result is loaded into the
// output register (decode runs from the input register into the result register).
// Throughput: one byte per cycle while the output does not stall, limited by the single decode stage.
// Bytes that only extend a sequence produce no result.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// decoder to idle with no sequence in progress.
module utf8_stream_decoder_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  utf8d_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utf8d_pkg::out_item_t out_item_o
);
  import utf8d_pkg::*;

  logic      out_ready;
  logic      advance;
  in_item_t  held_item;
  logic      res_valid;
  out_item_t res;

  utf8d_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .down_ready_i(out_ready),
    .advance_o   (advance),
    .item_o      (held_item)
  );

  utf8d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .item_i     (held_item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  utf8d_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_valid_i(res_valid),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/core/utf8d_in_stage.sv]
module utf8d_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  utf8d_pkg::in_item_t in_item_i,
  input  logic                down_ready_i,
  output logic                advance_o,
  output utf8d_pkg::in_item_t item_o
);
  import utf8d_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_stall_o = valid_q && !down_ready_i;
  assign take       = in_valid_i && !in_stall_o;
  assign advance_o  = valid_q && down_ready_i;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

endmodule

[rtl/core/utf8d_decode.sv]
module utf8d_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  utf8d_pkg::in_item_t  item_i,
  output logic                 res_valid_o,
  output utf8d_pkg::out_item_t res_o
);
  import utf8d_pkg::*;

  logic [CpW-1:0]    partial_q, partial_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CountW-1:0] len_q, len_d;

  logic [ByteW-1:0]  b;
  logic              eos;
  lead_e             cls;
  logic [CpW-1:0]    shifted;
  logic [RemW-1:0]   rem_dec;

  assign b       = item_i.data_byte;
  assign eos     = item_i.end_of_string;
  assign cls     = classify_lead(b);
  assign shifted = {partial_q[CpW-7:0], b[5:0]};
  assign rem_dec = rem_q - RemW'(1);

  always_comb begin
    partial_d   = partial_q;
    rem_d       = rem_q;
    len_d       = len_q;
    res_valid_o = 1'b0;
    res_o       = '{code_point: CpW'(b), byte_count: CountW'(1),
                    truncated: 1'b0, string_end: eos};
    if (rem_q == '0) begin
      case (cls)
        LeadSingle: begin
          res_valid_o = 1'b1;
        end
        LeadTwo: begin
          partial_d = CpW'(b[4:0]);
          rem_d     = RemW'(1);
          len_d     = CountW'(2);
        end
        LeadThree: begin
          partial_d = CpW'(b[3:0]);
          rem_d     = RemW'(2);
          len_d     = CountW'(3);
        end
        LeadFour: begin
          partial_d = CpW'(b[2:0]);
          rem_d     = RemW'(3);
          len_d     = CountW'(4);
        end
        default: begin
          res_valid_o = 1'b1;
        end
      endcase
      if (cls != LeadSingle && eos) begin
        // multi-byte lead as the last byte
        res_valid_o = 1'b1;
        res_o       = '{code_point: ReplacementCp, byte_count: CountW'(1),
                        truncated: 1'b1, string_end: 1'b1};
        partial_d   = '0;
        rem_d       = '0;
        len_d       = '0;
      end
    end else begin
      partial_d = shifted;
      rem_d     = rem_dec;
      if (rem_dec == '0) begin
        res_valid_o = 1'b1;
        res_o       = '{code_point: shifted, byte_count: len_q,
                        truncated: 1'b0, string_end: eos};
        partial_d   = '0;
        len_d       = '0;
      end else if (eos) begin
        res_valid_o = 1'b1;
        res_o       = '{code_point: ReplacementCp,
                        byte_count: len_q - CountW'(rem_dec),
                        truncated: 1'b1, string_end: 1'b1};
        partial_d   = '0;
        rem_d       = '0;
        len_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      rem_q     <= '0;
      len_q     <= '0;
    end else if (advance_i) begin
      partial_q <= partial_d;
      rem_q     <= rem_d;
      len_q     <= len_d;
    end
  end

  // idle means a cleared sequence state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == '0 |-> (partial_q == '0 && len_q == '0))
    else $error("idle decoder holds stale sequence state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0 |-> (len_q > CountW'(rem_q) && len_q <= CountW'(4)))
    else $error("sequence length inconsistent with bytes remaining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && res_valid_o && res_o.truncated) |->
      (res_o.code_point == ReplacementCp && res_o.string_end))
    else $error("truncated item without replacement code point");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && rem_q != '0 && !item_i.end_of_string && rem_q != RemW'(1)) |=>
      (rem_q == $past(rem_q) - RemW'(1)))
    else $error("continuation byte did not count down");

endmodule

[rtl/core/utf8d_out_stage.sv]
module utf8d_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 res_valid_i,
  input  utf8d_pkg::out_item_t res_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utf8d_pkg::out_item_t out_item_o
);
  import utf8d_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;
  logic      fill;

  assign ready_o     = !valid_q || !out_stall_i;
  assign fill        = load_i && res_valid_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (fill) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      item_q <= res_i;
    end
  end

endmodule
